### rtl/fsc_pkg.sv
// fsc_pkg: shared constants and types for the frustum sphere cull block
// no dependencies
`timescale 1ns / 1ps
package fsc_pkg;
  localparam int VW = 32;
  localparam int FB = 16;
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_TEST = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  typedef logic signed [VW-1:0] val_t;

  function automatic val_t sat33(input logic signed [VW:0] v);
    if (v > $signed({2'b00, {(VW-1){1'b1}}})) sat33 = {1'b0, {(VW-1){1'b1}}};
    else if (v < $signed({2'b11, {(VW-1){1'b0}}})) sat33 = {1'b1, {(VW-1){1'b0}}};
    else sat33 = v[VW-1:0];
  endfunction
endpackage

### rtl/frustum_sphere_cull.sv
// frustum_sphere_cull: matrix load, plane rebuild and sphere test over two memories
// depends on fsc_pkg and fsc_div
//
// channel  | ports                                   | dir
// request  | start, busy, in_mode ... in_radius      | in
// result   | out_valid, out_inside_res               | out
//
// load: four memory writes. sphere test: per plane four plane reads through the shared
// multiply-add and one compare, the reads going one at a time through the single memory
// read port; the result comes in the first idle cycle.
// rebuild: per plane 8 reads, a 32-step square root and four divides on the serial divider
// (no divides for a zero normal).
// reset clears the matrix memory and plane memory in one pass while busy.
// the receiver cannot stall; out_valid is high for one cycle.
`timescale 1ns / 1ps
module frustum_sphere_cull (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_column,
  input  logic signed [31:0] in_col_x,
  input  logic signed [31:0] in_col_y,
  input  logic signed [31:0] in_col_z,
  input  logic signed [31:0] in_col_w,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0] in_radius,
  output logic        out_valid,
  output logic        out_inside_res
);
  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_LOAD = 11'b00000000100,
    S_MRD  = 11'b00000001000,
    S_MCMB = 11'b00000010000,
    S_SQRT = 11'b00000100000,
    S_DIV  = 11'b00001000000,
    S_DWR  = 11'b00010000000,
    S_TRD  = 11'b00100000000,
    S_TACC = 11'b01000000000,
    S_TCMP = 11'b10000000000
  } st_t;

  st_t st_r, st_nxt;
  fsc_pkg::val_t mat_mem [16];
  fsc_pkg::val_t pl_mem [24];
  fsc_pkg::val_t mat_q, pl_q;
  logic        mat_we, pl_we;
  logic [3:0]  mat_wa, mat_ra;
  logic [4:0]  pl_wa, pl_ra;
  fsc_pkg::val_t mat_wd, pl_wd;

  logic [4:0]  clr_r, clr_nxt;
  logic [1:0]  col_r, col_nxt;
  logic [2:0]  pl_r, pl_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  j_r, j_nxt;
  fsc_pkg::val_t w_r, w_nxt;
  fsc_pkg::val_t cmp_r [4];
  fsc_pkg::val_t cmp_nxt [4];
  fsc_pkg::val_t in_col_x_r, in_col_y_r, in_col_z_r, in_col_w_r;
  logic [63:0] sq_r, sq_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  it_r, it_nxt;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [30:0] rad_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic inside_r, inside_nxt;
  logic ov_nxt;
  logic div_go, div_done;
  logic [63:0] div_num, div_den, div_q;

  fsc_div u_div (.clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num),
                 .den(div_den), .done(div_done), .quo(div_q));

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_wa] <= mat_wd;
    mat_q <= mat_mem[mat_ra];
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    pl_q <= pl_mem[pl_ra];
  end

  logic signed [32:0] cmb;
  logic [31:0] mag;
  logic [63:0] msq;
  logic [65:0] sqt;
  logic signed [63:0] prod, rnd;
  logic signed [31:0] posv;
  logic [64:0] qrnd;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; col_nxt = col_r; pl_nxt = pl_r;
    k_nxt = k_r; j_nxt = j_r; w_nxt = w_r;
    for (int i = 0; i < 4; i++) cmp_nxt[i] = cmp_r[i];
    sq_nxt = sq_r; root_nxt = root_r; it_nxt = it_r;
    acc_nxt = acc_r; inside_nxt = inside_r; ov_nxt = 1'b0;
    mat_we = 1'b0; mat_wa = '0; mat_wd = '0; mat_ra = '0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0; pl_ra = '0;
    div_go = 1'b0; div_num = '0; div_den = {32'd0, root_r};
    cmb = '0; mag = '0; msq = '0; sqt = '0; prod = '0; rnd = '0; posv = '0;
    qrnd = '0;
    unique case (st_r)
      S_CLR: begin
        pl_we = 1'b1; pl_wa = clr_r;
        mat_we = 1'b1; mat_wa = clr_r[3:0];
        clr_nxt = clr_r + 5'd1;
        if (clr_r == 5'd23) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          col_nxt = in_column; k_nxt = '0; pl_nxt = '0; j_nxt = '0;
          inside_nxt = 1'b1;
          if (in_mode == fsc_pkg::MODE_LOAD) st_nxt = S_LOAD;
          else if (in_mode == fsc_pkg::MODE_BUILD) st_nxt = S_MRD;
          else if (in_mode == fsc_pkg::MODE_TEST) st_nxt = S_TRD;
        end
      end
      S_LOAD: begin
        mat_we = 1'b1; mat_wa = {col_r, k_r[1:0]};
        unique case (k_r[1:0])
          2'd0: mat_wd = in_col_x_r;
          2'd1: mat_wd = in_col_y_r;
          2'd2: mat_wd = in_col_z_r;
          default: mat_wd = in_col_w_r;
        endcase
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd3) st_nxt = S_IDLE;
      end
      S_MRD: begin
        // k even reads w of column j, odd reads row entry
        mat_ra = k_r[0] ? {j_r, pl_r[2:1]} : {j_r, 2'd3};
        k_nxt = k_r + 3'd1;
        st_nxt = S_MCMB;
      end
      S_MCMB: begin
        if (!k_r[0]) begin
          cmp_nxt[j_r] = '0;
          if (pl_r == 3'd0 || pl_r == 3'd3 || pl_r == 3'd4)
            cmb = {w_r[31], w_r} + {mat_q[31], mat_q};
          else
            cmb = {w_r[31], w_r} - {mat_q[31], mat_q};
          cmp_nxt[j_r] = fsc_pkg::sat33(cmb);
          j_nxt = j_r + 2'd1;
          k_nxt = '0;
          if (j_r == 2'd3) begin
            st_nxt = S_SQRT; sq_nxt = '0; it_nxt = '0;
          end else st_nxt = S_MRD;
        end else begin
          w_nxt = mat_q;
          st_nxt = S_MRD;
        end
      end
      S_SQRT: begin
        if (it_r < 6'd3) begin
          mag = cmp_r[it_r[1:0]][31] ? 32'(-cmp_r[it_r[1:0]]) : cmp_r[it_r[1:0]];
          msq = {32'd0, mag} * {32'd0, mag};
          sqt = {2'b0, sq_r} + {2'b0, msq};
          sq_nxt = sqt[63:0];
          it_nxt = it_r + 6'd1;
          if (it_r == 6'd2) begin
            root_nxt = '0; it_nxt = 6'd32;
          end
        end else begin
          // one result bit per cycle, msb first
          it_nxt = it_r + 6'd1;
          st_nxt = S_SQRT;
          begin
            logic [31:0] cand;
            logic [4:0] b;
            b = 5'(6'd63 - it_r);
            cand = root_r | (32'd1 << b);
            if ({32'd0, cand} * {32'd0, cand} <= sq_r) root_nxt = cand;
          end
          if (it_r == 6'd63) begin
            st_nxt = S_DIV; j_nxt = '0; it_nxt = '0;
          end
        end
      end
      S_DIV: begin
        if (root_r == '0) begin
          pl_we = 1'b1; pl_wa = 5'({pl_r, j_r}); pl_wd = '0;
          j_nxt = j_r + 2'd1;
          if (j_r == 2'd3) st_nxt = S_DWR;
        end else if (it_r == '0) begin
          mag = cmp_r[j_r][31] ? 32'(-cmp_r[j_r]) : cmp_r[j_r];
          div_go = 1'b1;
          div_num = ({32'd0, mag} << fsc_pkg::FB) + {33'd0, root_r[31:1]};
          it_nxt = 6'd1;
        end else if (div_done) begin
          qrnd = {1'b0, div_q};
          if (cmp_r[j_r][31])
            pl_wd = (qrnd > 65'h080000000) ? 32'h80000000 : 32'(-div_q);
          else
            pl_wd = (qrnd > 65'h07fffffff) ? 32'h7fffffff : div_q[31:0];
          pl_we = 1'b1; pl_wa = 5'({pl_r, j_r});
          it_nxt = '0;
          j_nxt = j_r + 2'd1;
          if (j_r == 2'd3) st_nxt = S_DWR;
        end
      end
      S_DWR: begin
        pl_nxt = pl_r + 3'd1; j_nxt = '0; k_nxt = '0;
        st_nxt = (pl_r == 3'd5) ? S_IDLE : S_MRD;
      end
      S_TRD: begin
        pl_ra = 5'({pl_r, j_r});
        st_nxt = S_TACC;
      end
      S_TACC: begin
        unique case (j_r)
          2'd0: posv = px_r;
          2'd1: posv = py_r;
          2'd2: posv = pz_r;
          default: posv = '0;
        endcase
        if (j_r == 2'd0) acc_nxt = '0;
        prod = pl_q * posv;
        rnd = (prod + (64'sd1 <<< (fsc_pkg::FB - 1))) >>> fsc_pkg::FB;
        if (j_r == 2'd3) acc_nxt = acc_r + 64'(pl_q);
        else if (j_r == 2'd0) acc_nxt = rnd;
        else acc_nxt = acc_r + rnd;
        j_nxt = j_r + 2'd1;
        st_nxt = (j_r == 2'd3) ? S_TCMP : S_TRD;
      end
      S_TCMP: begin
        if (acc_r <= -$signed({33'd0, rad_r})) inside_nxt = 1'b0;
        pl_nxt = pl_r + 3'd1;
        if (pl_r == 3'd5 || acc_r <= -$signed({33'd0, rad_r})) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else st_nxt = S_TRD;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; out_valid <= ov_nxt;
    end
    out_inside_res <= inside_nxt;
    col_r <= col_nxt; pl_r <= pl_nxt; k_r <= k_nxt; j_r <= j_nxt; w_r <= w_nxt;
    for (int i = 0; i < 4; i++) cmp_r[i] <= cmp_nxt[i];
    sq_r <= sq_nxt; root_r <= root_nxt; it_r <= it_nxt;
    acc_r <= acc_nxt; inside_r <= inside_nxt;
    if (st_r == S_IDLE && start) begin
      in_col_x_r <= in_col_x; in_col_y_r <= in_col_y;
      in_col_z_r <= in_col_z; in_col_w_r <= in_col_w;
      px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z; rad_r <= in_radius;
    end
  end

  assign busy = (st_r != S_IDLE);
endmodule

### rtl/fsc_div.sv
// fsc_div: serial unsigned restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module fsc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] q_r, q_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        act_r, act_nxt;
  logic [64:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    act_nxt = act_r;
    sh = {rem_r, q_r[63]};
    done = 1'b0;
    if (go) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      act_nxt = 1'b1;
    end else if (act_r) begin
      if (sh >= {1'b0, den}) begin
        rem_nxt = 64'(sh - {1'b0, den});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        act_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end
  assign quo = q_nxt;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) act_r <= 1'b0;
    else act_r <= act_nxt;
  end
endmodule

### tb/fsc_checker.sv
// fsc_checker: watches requests and results of frustum_sphere_cull, predicts the
// inside flag from its own matrix and plane copies and counts mismatches
// depends on fsc_pkg
`timescale 1ns / 1ps
module fsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_column,
  input  logic signed [31:0] in_col_x,
  input  logic signed [31:0] in_col_y,
  input  logic signed [31:0] in_col_z,
  input  logic signed [31:0] in_col_w,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0] in_radius,
  input  logic        out_valid,
  input  logic        out_inside_res,
  output int          fail_count,
  output int          pending,
  output int          tests_seen,
  output int          culled_seen
);
  longint mat [16];
  longint pln [24];
  bit inside_q [$];

  function automatic longint clamp_val(longint v);
    longint hi;
    hi = (64'sd1 <<< (fsc_pkg::VW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_fix(longint p);
    longint q;
    q = p + (64'sd1 <<< (fsc_pkg::FB - 1));
    return q >>> fsc_pkg::FB;
  endfunction

  task automatic rebuild_planes();
    int rowsel [6] = '{0, 0, 1, 1, 2, 2};
    int sgn [6] = '{1, -1, -1, 1, 1, -1};
    longint comp [4];
    longint unsigned sumsq, len, m, q;
    for (int p = 0; p < 6; p++) begin
      sumsq = 0;
      for (int j = 0; j < 4; j++)
        comp[j] = clamp_val(sgn[p] > 0 ? mat[j*4+3] + mat[j*4+rowsel[p]]
                                        : mat[j*4+3] - mat[j*4+rowsel[p]]);
      for (int j = 0; j < 3; j++) begin
        m = comp[j] < 0 ? -comp[j] : comp[j];
        sumsq += m * m;
      end
      len = root_floor(sumsq);
      for (int j = 0; j < 4; j++) begin
        if (len == 0) begin
          pln[p*4+j] = 0;
        end else begin
          m = comp[j] < 0 ? -comp[j] : comp[j];
          q = ((m << fsc_pkg::FB) + len / 2) / len;
          pln[p*4+j] = clamp_val(comp[j] < 0 ? -longint'(q) : longint'(q));
        end
      end
    end
  endtask

  function automatic bit sphere_inside(longint px, longint py, longint pz, longint rad);
    longint d;
    for (int p = 0; p < 6; p++) begin
      d = round_fix(pln[p*4] * px) + round_fix(pln[p*4+1] * py)
        + round_fix(pln[p*4+2] * pz) + pln[p*4+3];
      if (d <= -rad) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    bit exp_in;
    if (!rst_n) begin
      foreach (mat[i]) mat[i] = 0;
      foreach (pln[i]) pln[i] = 0;
      inside_q.delete();
      fail_count <= 0;
      pending <= 0;
      tests_seen <= 0;
      culled_seen <= 0;
    end else begin
      if (out_valid) begin
        if (inside_q.size() == 0) begin
          $error("unexpected result inside_res=%0d", out_inside_res);
          fail_count <= fail_count + 1;
        end else begin
          exp_in = inside_q.pop_front();
          if (exp_in != out_inside_res) begin
            $error("inside_res expected %0d actual %0d", exp_in, out_inside_res);
            fail_count <= fail_count + 1;
          end
          if (!exp_in) culled_seen <= culled_seen + 1;
        end
      end
      if (start && !busy) begin
        case (in_mode)
          fsc_pkg::MODE_LOAD: begin
            mat[in_column*4+0] = clamp_val(in_col_x);
            mat[in_column*4+1] = clamp_val(in_col_y);
            mat[in_column*4+2] = clamp_val(in_col_z);
            mat[in_column*4+3] = clamp_val(in_col_w);
          end
          fsc_pkg::MODE_BUILD: rebuild_planes();
          fsc_pkg::MODE_TEST: begin
            inside_q.push_back(sphere_inside(clamp_val(in_pos_x), clamp_val(in_pos_y),
                                             clamp_val(in_pos_z), longint'(in_radius)));
            tests_seen <= tests_seen + 1;
          end
          default: ;
        endcase
      end
      pending <= inside_q.size();
    end
  end
endmodule

### tb/tb_frustum_sphere_cull.sv
// tb_frustum_sphere_cull: drives load, rebuild, sphere test and unused-mode requests with random gaps
// depends on fsc_pkg, frustum_sphere_cull and fsc_checker
`timescale 1ns / 1ps
module tb_frustum_sphere_cull;
  localparam int WATCH_LIMIT = 20000;

  logic clk, rst_n, start, busy, out_valid, out_inside_res;
  logic [1:0] in_mode, in_column;
  logic signed [31:0] in_col_x, in_col_y, in_col_z, in_col_w, in_pos_x, in_pos_y, in_pos_z;
  logic [30:0] in_radius;
  int fail_count, pending, tests_seen, culled_seen;
  int idle_pct;
  int quiet = 0;
  int n_req;

  frustum_sphere_cull DUT (.*);
  fsc_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (start && !busy || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCH_LIMIT) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [1:0] m, logic [1:0] c, logic [31:0] cx, logic [31:0] cy,
                      logic [31:0] cz, logic [31:0] cw, logic [31:0] px, logic [31:0] py,
                      logic [31:0] pz, logic [30:0] r);
    do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    start <= 1'b1;
    in_mode <= m; in_column <= c;
    in_col_x <= cx; in_col_y <= cy; in_col_z <= cz; in_col_w <= cw;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz; in_radius <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    n_req++;
  endtask

  task automatic load_col(int c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [31:0] w);
    send(fsc_pkg::MODE_LOAD, 2'(c), x, y, z, w, $urandom, $urandom, $urandom,
         31'($urandom));
  endtask

  task automatic test_sphere(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [30:0] r);
    send(fsc_pkg::MODE_TEST, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
         px, py, pz, r);
  endtask

  task automatic random_phase(int count);
    int k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 29) == 0) begin
        for (int c = 0; c < 4; c++) load_col(c, rnd_val(), rnd_val(), rnd_val(), rnd_val());
        send(fsc_pkg::MODE_BUILD, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 31'($urandom));
        k += 5;
      end else if ($urandom_range(0, 19) == 0) begin
        send(fsc_pkg::MODE_UNUSED, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 31'($urandom));
        k++;
      end else begin
        if ($urandom_range(0, 2) == 0)
          test_sphere(rnd_val(), rnd_val(), rnd_val(), 31'($urandom));
        else
          test_sphere($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000,
                      $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000,
                      $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000,
                      31'($urandom_range(0, 32'h30000)));
        k++;
      end
    end
  endtask

  initial begin
    rst_n = 0; start = 0; in_mode = 0; in_column = 0;
    in_col_x = 0; in_col_y = 0; in_col_z = 0; in_col_w = 0;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0; in_radius = 0;
    idle_pct = 0; n_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // planes never rebuilt: zero radius culls, nonzero passes
    test_sphere(32'h7fffffff, 32'h80000000, 0, 0);
    test_sphere(0, 0, 0, 31'h7fffffff);
    // zero normal planes from an all-zero matrix
    send(fsc_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    test_sphere(32'h00010000, 0, 0, 1);
    // identity-like matrix, unit cube frustum
    load_col(0, 32'h00010000, 0, 0, 0);
    load_col(1, 0, 32'h00010000, 0, 0);
    load_col(2, 0, 0, 32'h00010000, 0);
    load_col(3, 0, 0, 0, 32'h00010000);
    send(fsc_pkg::MODE_BUILD, 3, '1, '1, '1, '1, '1, '1, '1, '1);
    test_sphere(0, 0, 0, 0);
    test_sphere(32'h00030000, 0, 0, 32'h00010000);
    test_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    test_sphere(32'hfffe0000, 0, 0, 32'h00008000);
    send(fsc_pkg::MODE_UNUSED, 3, '1, '1, '1, '1, '1, '1, '1, '1);
    // saturating extremes in every column
    for (int c = 0; c < 4; c++)
      load_col(c, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send(fsc_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    test_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    test_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
    // hold off until every expected result has come
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    idle_pct = 23;
    random_phase(560);
    idle_pct = 72;
    random_phase(540);
    idle_pct = 0;
    random_phase(540);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("requests sent %0d, sphere tests %0d, culled %0d", n_req, tests_seen,
             culled_seen);
    $display("covered load, rebuild, test, unused mode, zero planes and saturation");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### frustum_sphere_cull.f
rtl/fsc_pkg.sv
rtl/fsc_div.sv
rtl/frustum_sphere_cull.sv
tb/fsc_checker.sv
tb/tb_frustum_sphere_cull.sv
